>>> rtl/core/qmr_pkg.sv
// Shared types and Hamilton product sign table for the quaternion unit.
`default_nettype none

package qmr_pkg;

  // Edges from an accepted item to its result strobe
  localparam int unsigned PIPE_LATENCY = 4;

  // Term j of component k pairs a[j] with b[k ^ j]; bit j set means subtract
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  typedef struct packed {
    logic valid;
    logic mode;
    logic ovf;
  } qmr_ctl_t;

endpackage : qmr_pkg

`default_nettype wire

>>> rtl/core/qmr_mul4x4.sv
// Registered outer product of two four-component signed vectors.
`default_nettype none

module qmr_mul4x4
  import qmr_pkg::*;
#(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qmr_ctl_t                    ctl_i,
  input  logic signed [A_W-1:0]       a_i [4],
  input  logic signed [B_W-1:0]       b_i [4],
  output qmr_ctl_t                    ctl_o,
  output logic signed [A_W+B_W-1:0]   prod_o [4][4]
);

  localparam int unsigned PROD_W = A_W + B_W;

  qmr_ctl_t                  ctl_r;
  logic signed [PROD_W-1:0]  prod_r   [4][4];
  logic signed [PROD_W-1:0]  prod_nxt [4][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = PROD_W'(a_i[i]) * PROD_W'(b_i[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign ctl_o  = ctl_r;
  assign prod_o = prod_r;

endmodule : qmr_mul4x4

`default_nettype wire

>>> rtl/core/qmr_hsum.sv
// Hamilton sums of products (optionally with b conjugated) with floor shift, saturation, bypass and overflow merge.
`default_nettype none

module qmr_hsum
  import qmr_pkg::*;
#(
  parameter int unsigned A_W       = 16,
  parameter int unsigned B_W       = 16,
  parameter int unsigned OUT_W     = 24,
  parameter int unsigned NARROW_W  = 16,
  parameter int unsigned FRAC_BITS = 12,
  parameter bit          CONJ_B    = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qmr_ctl_t                    ctl_i,
  input  logic signed [A_W+B_W-1:0]   prod_i [4][4],
  input  logic                        narrow_i,
  input  logic                        ovf_en_i,
  input  logic [3:0]                  byp_en_i,
  input  logic signed [OUT_W-1:0]     byp_val_i [4],
  output qmr_ctl_t                    ctl_o,
  output logic signed [OUT_W-1:0]     res_o [4]
);

  localparam int unsigned SUM_W = A_W + B_W + 2;
  localparam logic signed [OUT_W-1:0] MAX_W = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] MIN_W = ~MAX_W;
  localparam logic signed [OUT_W-1:0] MAX_N =
    OUT_W'((64'd1 << (NARROW_W - 1)) - 64'd1);
  localparam logic signed [OUT_W-1:0] MIN_N = ~MAX_N;

  qmr_ctl_t                  ctl_r;
  qmr_ctl_t                  ctl_nxt;
  logic signed [OUT_W-1:0]   res_r   [4];
  logic signed [OUT_W-1:0]   res_nxt [4];
  logic signed [SUM_W-1:0]   sum     [4];
  logic signed [SUM_W-1:0]   sh      [4];
  logic [3:0]                sat;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = '0;
      for (int j = 0; j < 4; j++) begin
        if (HAM_NEG[k][j] ^ (CONJ_B && ((k ^ j) != 0))) begin
          sum[k] = sum[k] - SUM_W'(prod_i[j][2'(k ^ j)]);
        end else begin
          sum[k] = sum[k] + SUM_W'(prod_i[j][2'(k ^ j)]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sh[k] = sum[k] >>> FRAC_BITS;
      if (narrow_i) begin
        sat[k] = !((&sh[k][SUM_W-1:NARROW_W-1]) || !(|sh[k][SUM_W-1:NARROW_W-1]));
        res_nxt[k] = sat[k] ? (sh[k][SUM_W-1] ? MIN_N : MAX_N) : sh[k][OUT_W-1:0];
      end else begin
        sat[k] = !((&sh[k][SUM_W-1:OUT_W-1]) || !(|sh[k][SUM_W-1:OUT_W-1]));
        res_nxt[k] = sat[k] ? (sh[k][SUM_W-1] ? MIN_W : MAX_W) : sh[k][OUT_W-1:0];
      end
      if (byp_en_i[k]) begin
        res_nxt[k] = byp_val_i[k];
      end
    end
    ctl_nxt     = ctl_i;
    ctl_nxt.ovf = ctl_i.ovf | (ovf_en_i & (|sat));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign ctl_o = ctl_r;
  assign res_o = res_r;

endmodule : qmr_hsum

`default_nettype wire

>>> rtl/core/quaternion_multiply_rotate_core.sv
// Top level of the pipelined fixed-point quaternion product and rotation unit.
//
// Input channel: drive the item on the in_* ports and raise start; the item
// is taken at a rising edge with start high and busy low. busy is high only
// during reset and in the first cycle after it, so one item may enter every cycle.
// in_mode low gives the Hamilton product p*r; high rotates (r_x, r_y, r_z)
// by p as p*v*conj(p), with out_w forced to zero.
// Result channel: out_valid is high for one cycle with out_w, out_x, out_y,
// out_z and out_overflow; the receiver takes it in that cycle and cannot
// stall it. out_overflow flags saturation of any component, intermediate
// or final.
// Pipeline: four registers, in order the first multiplier array, first sum
// and saturate, second multiplier array, second sum and saturate.
// Throughput: one item per cycle while busy is low, with up to four items in flight.
// Reset: synchronous, active low; drops every item in flight.
`default_nettype none

module quaternion_multiply_rotate_core
  import qmr_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic signed [COMP_WIDTH-1:0] in_p_w,
  input  logic signed [COMP_WIDTH-1:0] in_p_x,
  input  logic signed [COMP_WIDTH-1:0] in_p_y,
  input  logic signed [COMP_WIDTH-1:0] in_p_z,
  input  logic signed [COMP_WIDTH-1:0] in_r_w,
  input  logic signed [COMP_WIDTH-1:0] in_r_x,
  input  logic signed [COMP_WIDTH-1:0] in_r_y,
  input  logic signed [COMP_WIDTH-1:0] in_r_z,
  output logic                         out_valid,
  output logic signed [COMP_WIDTH-1:0] out_w,
  output logic signed [COMP_WIDTH-1:0] out_x,
  output logic signed [COMP_WIDTH-1:0] out_y,
  output logic signed [COMP_WIDTH-1:0] out_z,
  output logic                         out_overflow
);

  localparam int unsigned C_W     = COMP_WIDTH;
  localparam int unsigned INTER_W = (C_W + 8 > 32) ? 32 : C_W + 8;

  logic                       busy_r;
  qmr_ctl_t                   ctl_in;
  qmr_ctl_t                   ctl_a;
  qmr_ctl_t                   ctl_b;
  qmr_ctl_t                   ctl_c;
  qmr_ctl_t                   ctl_d;
  logic signed [C_W-1:0]      p_in   [4];
  logic signed [C_W-1:0]      r_in   [4];
  logic signed [C_W-1:0]      p_a_r  [4];
  logic signed [C_W-1:0]      p_b_r  [4];
  logic signed [2*C_W-1:0]    prod_a [4][4];
  logic signed [INTER_W-1:0]  t_b    [4];
  logic signed [INTER_W-1:0]  t_c_r  [4];
  logic signed [INTER_W+C_W-1:0] prod_c [4][4];
  logic signed [C_W-1:0]      byp_d  [4];
  logic signed [C_W-1:0]      res_d  [4];
  logic signed [INTER_W-1:0]  byp_b  [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  always_comb begin
    ctl_in.valid = start && !busy_r;
    ctl_in.mode  = in_mode;
    ctl_in.ovf   = 1'b0;
    p_in[0] = in_p_w;
    p_in[1] = in_p_x;
    p_in[2] = in_p_y;
    p_in[3] = in_p_z;
    r_in[0] = in_mode ? '0 : in_r_w;
    r_in[1] = in_r_x;
    r_in[2] = in_r_y;
    r_in[3] = in_r_z;
    for (int k = 0; k < 4; k++) begin
      byp_b[k] = '0;
      byp_d[k] = ctl_c.mode ? '0 : t_c_r[k][C_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    p_a_r <= p_in;
    p_b_r <= p_a_r;
    t_c_r <= t_b;
  end

  qmr_mul4x4 #(
    .A_W(C_W),
    .B_W(C_W)
  ) u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_in),
    .a_i   (p_in),
    .b_i   (r_in),
    .ctl_o (ctl_a),
    .prod_o(prod_a)
  );

  qmr_hsum #(
    .A_W      (C_W),
    .B_W      (C_W),
    .OUT_W    (INTER_W),
    .NARROW_W (C_W),
    .FRAC_BITS(FRAC_BITS),
    .CONJ_B   (1'b0)
  ) u_sum_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_a),
    .prod_i   (prod_a),
    .narrow_i (!ctl_a.mode),
    .ovf_en_i (1'b1),
    .byp_en_i (4'b0000),
    .byp_val_i(byp_b),
    .ctl_o    (ctl_b),
    .res_o    (t_b)
  );

  qmr_mul4x4 #(
    .A_W(INTER_W),
    .B_W(C_W)
  ) u_mul_c (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_b),
    .a_i   (t_b),
    .b_i   (p_b_r),
    .ctl_o (ctl_c),
    .prod_o(prod_c)
  );

  qmr_hsum #(
    .A_W      (INTER_W),
    .B_W      (C_W),
    .OUT_W    (C_W),
    .NARROW_W (C_W),
    .FRAC_BITS(FRAC_BITS),
    .CONJ_B   (1'b1)
  ) u_sum_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_c),
    .prod_i   (prod_c),
    .narrow_i (1'b0),
    .ovf_en_i (ctl_c.mode),
    .byp_en_i (ctl_c.mode ? 4'b0001 : 4'b1111),
    .byp_val_i(byp_d),
    .ctl_o    (ctl_d),
    .res_o    (res_d)
  );

  assign out_valid    = ctl_d.valid;
  assign out_overflow = ctl_d.ovf;
  assign out_w        = res_d[0];
  assign out_x        = res_d[1];
  assign out_y        = res_d[2];
  assign out_z        = res_d[3];

endmodule : quaternion_multiply_rotate_core

`default_nettype wire

>>> rtl/core/qmr_checker.sv
// Port-level assertions for the quaternion unit and their bind.
`default_nettype none

module qmr_checker
  import qmr_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_mode,
  input logic                         out_valid,
  input logic signed [COMP_WIDTH-1:0] out_w
);

  logic take;
  assign take = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##PIPE_LATENCY out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, PIPE_LATENCY))
    else $error("result without matching item");

  a_rotate_real_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(take && in_mode, PIPE_LATENCY)) |-> (out_w == '0))
    else $error("rotation result with nonzero real part");

  a_busy_only_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset recovery");

endmodule : qmr_checker

bind quaternion_multiply_rotate_core qmr_checker #(
  .COMP_WIDTH(COMP_WIDTH)
) u_qmr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_mode  (in_mode),
  .out_valid(out_valid),
  .out_w    (out_w)
);

`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the quaternion product and rotation core: directed table, then random items.
`default_nettype none

module tb_top;
  import qmr_pkg::*;

  localparam int CW = 16;
  localparam int FB = 12;
  localparam int IW = (CW + 8 > 32) ? 32 : CW + 8;
  localparam int N_RANDOM = 1200;
  localparam int QUIET_LO = 300;
  localparam int QUIET_HI = 700;
  localparam int DRAIN_AT = 800;
  localparam int CYCLE_LIMIT = 60000;

  localparam logic MODE_PRODUCT = 1'b0;
  localparam logic MODE_ROTATE  = 1'b1;

  localparam logic [CW-1:0] Q_ONE  = 16'd4096;
  localparam logic [CW-1:0] Q_MIN  = 16'h8000;
  localparam logic [CW-1:0] Q_MAX  = 16'h7fff;
  localparam logic [CW-1:0] Q_NEG1 = 16'hffff;
  localparam logic [CW-1:0] Q_COS45 = 16'd2896;

  typedef struct packed {
    logic          mode;
    logic [CW-1:0] p_w, p_x, p_y, p_z;
    logic [CW-1:0] r_w, r_x, r_y, r_z;
  } quat_item_t;

  typedef struct packed {
    logic [CW-1:0] w, x, y, z;
    logic          ovf;
  } quat_res_t;

  typedef struct packed {
    logic       typed;
    quat_item_t item;
    quat_res_t  res;
  } quat_row_t;

  localparam quat_res_t NO_RES = '0;
  localparam int NDIR = 18;

  localparam quat_row_t DIR_ROWS [NDIR] = '{
    '{1'b1, '{MODE_PRODUCT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{1'b1, '{MODE_PRODUCT, Q_ONE, 16'd0, 16'd0, 16'd0,
              16'd100, -16'sd200, 16'd300, -16'sd400},
      '{16'd100, -16'sd200, 16'd300, -16'sd400, 1'b0}},
    '{1'b1, '{MODE_PRODUCT, 16'd1, 16'd0, 16'd0, 16'd0, Q_NEG1, 16'd0, 16'd0, 16'd0},
      '{Q_NEG1, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{1'b1, '{MODE_PRODUCT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
      '{Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1}},
    '{1'b0, '{MODE_PRODUCT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
      NO_RES},
    '{1'b0, '{MODE_PRODUCT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
      NO_RES},
    '{1'b1, '{MODE_PRODUCT, 16'd0, Q_ONE, 16'd0, 16'd0, 16'd0, 16'd0, Q_ONE, 16'd0},
      '{16'd0, 16'd0, 16'd0, Q_ONE, 1'b0}},
    '{1'b1, '{MODE_PRODUCT, 16'd0, 16'd0, Q_ONE, 16'd0, 16'd0, Q_ONE, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0, -16'sd4096, 1'b0}},
    '{1'b1, '{MODE_PRODUCT, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1},
      '{Q_NEG1, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{1'b1, '{MODE_ROTATE, Q_ONE, 16'd0, 16'd0, 16'd0,
              16'd1234, 16'd100, -16'sd200, 16'd300},
      '{16'd0, 16'd100, -16'sd200, 16'd300, 1'b0}},
    '{1'b1, '{MODE_ROTATE, Q_ONE, 16'd0, 16'd0, 16'd0, Q_MAX, 16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{1'b1, '{MODE_ROTATE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{1'b0, '{MODE_ROTATE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
      NO_RES},
    '{1'b0, '{MODE_ROTATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
      NO_RES},
    '{1'b0, '{MODE_ROTATE, Q_COS45, 16'd0, 16'd0, Q_COS45, 16'd0, Q_ONE, 16'd0, 16'd0},
      NO_RES},
    '{1'b0, '{MODE_ROTATE, 16'd0, Q_MIN, 16'd0, 16'd0, 16'd0, Q_ONE, Q_ONE, Q_ONE},
      NO_RES},
    '{1'b0, '{MODE_ROTATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
      NO_RES},
    '{1'b0, '{MODE_ROTATE, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 16'd0, Q_MAX, Q_MIN, Q_MAX},
      NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic signed [CW-1:0] in_p_w = '0, in_p_x = '0, in_p_y = '0, in_p_z = '0;
  logic signed [CW-1:0] in_r_w = '0, in_r_x = '0, in_r_y = '0, in_r_z = '0;
  logic out_valid;
  logic signed [CW-1:0] out_w, out_x, out_y, out_z;
  logic out_overflow;

  quat_res_t pending_results [$];
  int mismatches = 0;
  int n_product = 0;
  int n_rotate = 0;
  int n_overflow = 0;
  int cycles = 0;

  quaternion_multiply_rotate_core #(
    .COMP_WIDTH(CW),
    .FRAC_BITS (FB)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_p_w      (in_p_w),
    .in_p_x      (in_p_x),
    .in_p_y      (in_p_y),
    .in_p_z      (in_p_z),
    .in_r_w      (in_r_w),
    .in_r_x      (in_r_x),
    .in_r_y      (in_r_y),
    .in_r_z      (in_r_z),
    .out_valid   (out_valid),
    .out_w       (out_w),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_overflow(out_overflow)
  );

  always #5 clk = ~clk;

  // Exact sum of four products, floor shift, saturate to w bits.
  function automatic longint sum_sat(input longint t0, t1, t2, t3, input int w,
                                     inout bit ovf);
    longint acc;
    longint hi;
    longint lo;
    acc = (t0 + t1 + t2 + t3) >>> FB;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (acc > hi) begin
      ovf = 1'b1;
      return hi;
    end
    if (acc < lo) begin
      ovf = 1'b1;
      return lo;
    end
    return acc;
  endfunction

  function automatic void hamilton(input longint a [4], input longint b [4], input int w,
                                   output longint o [4], inout bit ovf);
    o[0] = sum_sat(a[0] * b[0], -a[1] * b[1], -a[2] * b[2], -a[3] * b[3], w, ovf);
    o[1] = sum_sat(a[0] * b[1],  a[1] * b[0],  a[2] * b[3], -a[3] * b[2], w, ovf);
    o[2] = sum_sat(a[0] * b[2], -a[1] * b[3],  a[2] * b[0],  a[3] * b[1], w, ovf);
    o[3] = sum_sat(a[0] * b[3],  a[1] * b[2], -a[2] * b[1],  a[3] * b[0], w, ovf);
  endfunction

  function automatic quat_res_t quat_result(input quat_item_t item);
    longint p [4];
    longint v [4];
    longint t [4];
    longint o [4];
    longint pc [4];
    bit ovf;
    quat_res_t res;
    ovf = 1'b0;
    p[0] = longint'($signed(item.p_w));
    p[1] = longint'($signed(item.p_x));
    p[2] = longint'($signed(item.p_y));
    p[3] = longint'($signed(item.p_z));
    v[0] = longint'($signed(item.r_w));
    v[1] = longint'($signed(item.r_x));
    v[2] = longint'($signed(item.r_y));
    v[3] = longint'($signed(item.r_z));
    if (item.mode == MODE_PRODUCT) begin
      hamilton(p, v, CW, o, ovf);
    end else begin
      v[0] = 0;
      hamilton(p, v, IW, t, ovf);
      pc[0] = p[0];
      pc[1] = -p[1];
      pc[2] = -p[2];
      pc[3] = -p[3];
      hamilton(t, pc, CW, o, ovf);
      o[0] = 0;
    end
    res.w = CW'(o[0]);
    res.x = CW'(o[1]);
    res.y = CW'(o[2]);
    res.z = CW'(o[3]);
    res.ovf = ovf;
    return res;
  endfunction

  function automatic logic [CW-1:0] rand_comp(input int style);
    case (style)
      0: return CW'($urandom);
      1: return CW'(int'($urandom_range(0, 8192)) - 4096);
      default: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return Q_NEG1;
          3: return 16'd1;
          default: return 16'd0;
        endcase
      end
    endcase
  endfunction

  function automatic quat_item_t rand_item();
    quat_item_t item;
    int pick;
    int style;
    pick = $urandom_range(0, 9);
    style = (pick < 4) ? 0 : (pick < 7) ? 1 : (pick < 8) ? 2 : -1;
    item.mode = $urandom_range(0, 1) ? MODE_ROTATE : MODE_PRODUCT;
    item.p_w = rand_comp(style < 0 ? $urandom_range(0, 2) : style);
    item.p_x = rand_comp(style < 0 ? $urandom_range(0, 2) : style);
    item.p_y = rand_comp(style < 0 ? $urandom_range(0, 2) : style);
    item.p_z = rand_comp(style < 0 ? $urandom_range(0, 2) : style);
    item.r_w = rand_comp(style < 0 ? $urandom_range(0, 2) : style);
    item.r_x = rand_comp(style < 0 ? $urandom_range(0, 2) : style);
    item.r_y = rand_comp(style < 0 ? $urandom_range(0, 2) : style);
    item.r_z = rand_comp(style < 0 ? $urandom_range(0, 2) : style);
    return item;
  endfunction

  task automatic send_item(input quat_item_t item, input bit may_idle, input bit typed,
                           input quat_res_t typed_res);
    if (may_idle && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= item.mode;
    in_p_w <= item.p_w;
    in_p_x <= item.p_x;
    in_p_y <= item.p_y;
    in_p_z <= item.p_z;
    in_r_w <= item.r_w;
    in_r_x <= item.r_x;
    in_r_y <= item.r_y;
    in_r_z <= item.r_z;
    do @(posedge clk); while (!(start && !busy));
    pending_results.push_back(typed ? typed_res : quat_result(item));
    if (item.mode == MODE_ROTATE) n_rotate++;
    else n_product++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NDIR; i++) begin
      send_item(DIR_ROWS[i].item, 1'b1, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end
    drain_results();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == DRAIN_AT) drain_results();
      send_item(rand_item(), !(i >= QUIET_LO && i < QUIET_HI), 1'b0, NO_RES);
    end
    drain_results();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    $display("Sent %0d directed and %0d random items: %0d products, %0d rotations.",
             NDIR, N_RANDOM, n_product, n_rotate);
    $display("%0d results flagged overflow; idle gaps, a gap-free stretch and three drains.",
             n_overflow);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin : score
    quat_res_t want;
    if (rst_n && out_valid) begin
      if (out_overflow) n_overflow++;
      if (pending_results.size() == 0) begin
        $error("result with no item pending: w=%0d x=%0d y=%0d z=%0d",
               out_w, out_x, out_y, out_z);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_w !== want.w) begin
          $error("out_w: expected %0d, got %0d", $signed(want.w), out_w);
          mismatches++;
        end
        if (out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", $signed(want.x), out_x);
          mismatches++;
        end
        if (out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", $signed(want.y), out_y);
          mismatches++;
        end
        if (out_z !== want.z) begin
          $error("out_z: expected %0d, got %0d", $signed(want.z), out_z);
          mismatches++;
        end
        if (out_overflow !== want.ovf) begin
          $error("out_overflow: expected %0d, got %0d", want.ovf, out_overflow);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

`default_nettype wire
